### sv/u2d_pkg.sv
// ----------------------------------------------------------------------------
// u2d_pkg: shared types and constants for the decimal text converter
// Holds the result status codes, the state machine types and the command
// record that travels from the conversion front end to the digit emitter.
// ----------------------------------------------------------------------------
package u2d_pkg;

    localparam int MAX_DIGITS = 20;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CAP_ZERO  = 2'd1,
        ST_CAP_SMALL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } t_front_state;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic [MAX_DIGITS-1:0][3:0] bcd;
        logic [4:0]                 count;
        t_status                    status;
    } t_cmd;

endpackage

### sv/u2d_queue.sv
// ----------------------------------------------------------------------------
// u2d_queue: two-entry command queue
// Decouples the conversion front end from the digit emitter.
// ----------------------------------------------------------------------------
module u2d_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u2d_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output u2d_pkg::t_cmd o_data,
    output logic          o_empty
);

    u2d_pkg::t_cmd                  r_mem [u2d_pkg::Q_DEPTH];
    logic [u2d_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [u2d_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [u2d_pkg::Q_CNT_W-1:0]    r_count;
    logic                           w_do_push;
    logic                           w_do_pop;

    assign o_full    = (r_count == u2d_pkg::Q_CNT_W'(u2d_pkg::Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/u2d_front.sv
// ----------------------------------------------------------------------------
// u2d_front: request intake and binary to BCD conversion
// Converts the value four bits a cycle with shift-and-add-3, then counts
// the digits, checks them against the capacity and queues a command.
// ----------------------------------------------------------------------------
module u2d_front #(
    parameter int VALUE_BITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [63:0]   i_value,
    input  logic [7:0]    i_buffer_capacity,
    output logic          o_full,
    output logic          o_q_push,
    output u2d_pkg::t_cmd o_q_data,
    input  logic          i_q_full
);

    localparam int NDIG    = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int BCD_W   = NDIG * 4;
    localparam int STEPS   = (VALUE_BITS + 3) / 4;
    localparam int SHIFT_W = STEPS * 4;
    localparam int STEP_W  = $clog2(STEPS);

    u2d_pkg::t_front_state r_state;
    u2d_pkg::t_front_state n_state;

    logic [SHIFT_W-1:0] r_shift;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [STEP_W-1:0]  r_step;
    logic [7:0]         r_cap;
    logic               w_accept;
    logic               w_last_step;
    logic [4:0]         w_count;

    assign w_accept    = i_push && !o_full;
    assign w_last_step = (r_step == STEP_W'(STEPS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            u2d_pkg::FR_IDLE: if (i_push) n_state = u2d_pkg::FR_CONV;
            u2d_pkg::FR_CONV: if (w_last_step) n_state = u2d_pkg::FR_PUSH;
            u2d_pkg::FR_PUSH: if (!i_q_full) n_state = u2d_pkg::FR_IDLE;
            default:          n_state = u2d_pkg::FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_full   = 1'b1;
        o_q_push = 1'b0;
        unique case (r_state)
            u2d_pkg::FR_IDLE: o_full   = 1'b0;
            u2d_pkg::FR_CONV: o_full   = 1'b1;
            u2d_pkg::FR_PUSH: o_q_push = 1'b1;
            default:          o_full   = 1'b1;
        endcase
    end

    // four shift-and-add-3 steps, most significant bits first
    always_comb begin
        n_bcd = r_bcd;
        for (int b = 0; b < 4; b++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (n_bcd[d*4 +: 4] >= 4'd5) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], r_shift[SHIFT_W-1-b]};
        end
    end

    // digit count: position of the highest nonzero digit, at least one
    always_comb begin
        w_count = 5'd1;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] != 4'd0) begin
                w_count = 5'(d + 1);
            end
        end
    end

    always_comb begin
        o_q_data        = '0;
        o_q_data.bcd    = (u2d_pkg::MAX_DIGITS * 4)'(r_bcd);
        o_q_data.count  = w_count;
        if (r_cap == 8'd0) begin
            o_q_data.status = u2d_pkg::ST_CAP_ZERO;
        end else if ((8'(w_count) + 8'd1) > r_cap) begin
            o_q_data.status = u2d_pkg::ST_CAP_SMALL;
        end else begin
            o_q_data.status = u2d_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u2d_pkg::FR_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_step <= '0;
            end else if (r_state == u2d_pkg::FR_CONV) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_shift <= SHIFT_W'(i_value[VALUE_BITS-1:0]);
            r_bcd   <= '0;
            r_cap   <= i_buffer_capacity;
        end else if (r_state == u2d_pkg::FR_CONV) begin
            r_shift <= r_shift << 4;
            r_bcd   <= n_bcd;
        end
    end

endmodule

### sv/u2d_back.sv
// ----------------------------------------------------------------------------
// u2d_back: digit emitter
// Takes queued commands and sends one ASCII digit per cycle as popped, most
// significant first, or a single failure result, through an output register.
// ----------------------------------------------------------------------------
module u2d_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  u2d_pkg::t_cmd i_q_data,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [5:0]    o_digit_char,
    output logic [4:0]    o_digit_count,
    output logic [1:0]    o_status,
    output logic          o_last
);

    u2d_pkg::t_back_state r_state;
    u2d_pkg::t_back_state n_state;

    u2d_pkg::t_cmd r_cmd;
    logic [4:0]    r_rem;
    logic [4:0]    w_idx;
    logic          r_out_valid;
    logic          w_slot_free;
    logic          w_emit;
    logic          w_ok;
    logic [5:0]    r_char;
    logic [4:0]    r_count;
    logic [1:0]    r_status;
    logic          r_last;

    assign w_slot_free = !r_out_valid || i_pop;
    assign w_ok        = (r_cmd.status == u2d_pkg::ST_OK);
    assign w_idx       = r_rem - 5'd1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            u2d_pkg::BK_IDLE: if (!i_q_empty) n_state = u2d_pkg::BK_EMIT;
            u2d_pkg::BK_EMIT: if (w_slot_free && r_rem == 5'd1) n_state = u2d_pkg::BK_IDLE;
            default:          n_state = u2d_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            u2d_pkg::BK_IDLE: o_q_pop = !i_q_empty;
            u2d_pkg::BK_EMIT: w_emit  = w_slot_free;
            default:          o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= u2d_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
            r_rem <= (i_q_data.status == u2d_pkg::ST_OK) ? i_q_data.count : 5'd1;
        end else if (w_emit) begin
            r_rem <= r_rem - 5'd1;
        end
    end

    // failures carry no digit and no count
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char   <= w_ok ? (u2d_pkg::ASCII_ZERO + {2'b00, r_cmd.bcd[w_idx]}) : 6'd0;
            r_count  <= w_ok ? r_cmd.count : 5'd0;
            r_status <= r_cmd.status;
            r_last   <= (r_rem == 5'd1);
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_digit_char  = r_char;
    assign o_digit_count = r_count;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

### sv/u64_to_decimal_text_core.sv
// ----------------------------------------------------------------------------
// u64_to_decimal_text_core: unsigned integer to decimal ASCII text
// Front end converts, a two-entry queue buffers, back end emits digits.
// ----------------------------------------------------------------------------
// Converts the low VALUE_BITS bits of value into decimal ASCII digits, most
// significant first, one result per digit with the digit count and last set
// on the final one; capacity must cover the digits plus a terminator, else a
// single failure result (status 1 for zero capacity, 2 for too small) comes
// out instead. The front end runs the four-bits-a-cycle shift-and-add-3
// converter and takes no new request until it has queued the last one;
// the back end sends one digit per cycle through the output register
// while the receiver pops. The two run concurrently behind a two-entry
// queue, so a new request can convert while earlier digits still go out.
module u64_to_decimal_text_core #(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_value,
    input  logic [7:0]  i_buffer_capacity,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_digit_char,
    output logic [4:0]  o_digit_count,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic          w_q_push;
    logic          w_q_full;
    logic          w_q_pop;
    logic          w_q_empty;
    u2d_pkg::t_cmd w_q_wdata;
    u2d_pkg::t_cmd w_q_rdata;

    u2d_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_value           (i_value),
        .i_buffer_capacity (i_buffer_capacity),
        .o_full            (full),
        .o_q_push          (w_q_push),
        .o_q_data          (w_q_wdata),
        .i_q_full          (w_q_full)
    );

    u2d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    u2d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (w_q_rdata),
        .i_q_empty     (w_q_empty),
        .o_q_pop       (w_q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_digit_char  (o_digit_char),
        .o_digit_count (o_digit_count),
        .o_status      (o_status),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != u2d_pkg::ST_OK) |->
            (o_last && o_digit_count == 5'd0 && o_digit_char == 6'd0))
        else $error("failure result must be a lone result without digit");

    a_ok_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == u2d_pkg::ST_OK) |->
            (o_digit_char >= u2d_pkg::ASCII_ZERO
             && o_digit_char <= (u2d_pkg::ASCII_ZERO + 6'd9)
             && o_digit_count != 5'd0))
        else $error("ok result must carry a decimal digit and a count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("front end must be busy after taking a request");
`endif

endmodule

### verif/u64_to_decimal_text_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u64_to_decimal_text_core_tb: self-checking bench for the decimal text core
// Walks a table of boundary requests, then random requests with lengths and
// capacities spread around the fit boundary. Each popped digit result is
// checked against a local predictor or its table row, under random idling
// on both queue sides and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module u64_to_decimal_text_core_tb;

    localparam int          VALUE_BITS  = 64;
    localparam logic [63:0] VALUE_MASK  = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam int          DIGITS_MAX  = 20;
    localparam int          RAND_ITEMS  = 209;
    localparam int          QUIET_ITEMS = 30;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          HOLD_CYCLES = 300;
    localparam int          HOLD_AFTER  = 150;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [63:0] U64_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [5:0]       ch;
        logic [4:0]       count;
        u2d_pkg::t_status status;
        logic             last;
    } t_digit_result;

    typedef struct packed {
        logic [63:0]      value;
        logic [7:0]       cap;
        logic             typed;
        u2d_pkg::t_status status;
        logic [5:0]       ch;
        logic [4:0]       count;
    } t_stim_row;

    // typed rows carry their single expected result; the rest go to the predictor
    localparam int DIR_ROWS = 21;
    localparam t_stim_row DIRECTED [0:DIR_ROWS-1] = '{
        '{64'd0,    8'd0, 1'b1, u2d_pkg::ST_CAP_ZERO,  6'd0,                       5'd0},
        '{U64_MAX,  8'd0, 1'b1, u2d_pkg::ST_CAP_ZERO,  6'd0,                       5'd0},
        '{64'd0,    8'd1, 1'b1, u2d_pkg::ST_CAP_SMALL, 6'd0,                       5'd0},
        '{64'd0,    8'd2, 1'b1, u2d_pkg::ST_OK,        u2d_pkg::ASCII_ZERO,        5'd1},
        '{64'd9,    8'd2, 1'b1, u2d_pkg::ST_OK,        u2d_pkg::ASCII_ZERO + 6'd9, 5'd1},
        '{64'd10,   8'd2, 1'b1, u2d_pkg::ST_CAP_SMALL, 6'd0,                       5'd0},
        '{64'd10,   8'd3, 1'b0, u2d_pkg::ST_OK,        6'd0,                       5'd0},
        '{U64_MAX, 8'd21, 1'b0, u2d_pkg::ST_OK,        6'd0,                       5'd0},
        '{U64_MAX, 8'd20, 1'b1, u2d_pkg::ST_CAP_SMALL, 6'd0,                       5'd0},
        '{U64_MAX, 8'd255, 1'b0, u2d_pkg::ST_OK,       6'd0,                       5'd0},
        '{64'h8000_0000_0000_0000, 8'd255, 1'b0, u2d_pkg::ST_OK, 6'd0,             5'd0},
        '{64'd9999999999999999999, 8'd20, 1'b0, u2d_pkg::ST_OK, 6'd0,              5'd0},
        '{64'd9999999999999999999, 8'd19, 1'b1, u2d_pkg::ST_CAP_SMALL, 6'd0,       5'd0},
        '{64'd10000000000000000000, 8'd21, 1'b0, u2d_pkg::ST_OK, 6'd0,             5'd0},
        '{64'd1,   8'd255, 1'b0, u2d_pkg::ST_OK,       6'd0,                       5'd0},
        '{64'd99,  8'd3,   1'b0, u2d_pkg::ST_OK,       6'd0,                       5'd0},
        '{64'd100, 8'd3,   1'b1, u2d_pkg::ST_CAP_SMALL, 6'd0,                      5'd0},
        '{64'h5555_5555_5555_5555, 8'd22, 1'b0, u2d_pkg::ST_OK, 6'd0,              5'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 8'd255, 1'b0, u2d_pkg::ST_OK, 6'd0,             5'd0},
        '{64'd1234567890, 8'd11, 1'b0, u2d_pkg::ST_OK, 6'd0,                       5'd0},
        '{64'd0,   8'd255, 1'b0, u2d_pkg::ST_OK,       6'd0,                       5'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [63:0] i_value;
    logic [7:0]  i_buffer_capacity;
    logic        empty;
    logic        pop;
    logic [5:0]  o_digit_char;
    logic [4:0]  o_digit_count;
    logic [1:0]  o_status;
    logic        o_last;

    t_digit_result digits_due[$];
    int            error_cnt;
    int            popped_cnt;
    int            cycle_cnt;
    bit            quiet;

    u64_to_decimal_text_core #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_value          (i_value),
        .i_buffer_capacity(i_buffer_capacity),
        .empty            (empty),
        .pop              (pop),
        .o_digit_char     (o_digit_char),
        .o_digit_count    (o_digit_count),
        .o_status         (o_status),
        .o_last           (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int decimal_len(input logic [63:0] value);
        logic [63:0] v;
        int          len;
        v   = value;
        len = 0;
        do begin
            v = v / 64'd10;
            len++;
        end while (v != 64'd0 && len < DIGITS_MAX);
        return len;
    endfunction

    // queue the digit results one conversion request should produce
    function automatic void predict_conversion(input logic [63:0] value,
                                               input logic [7:0] cap);
        logic [63:0] v;
        logic [3:0]  dig [0:DIGITS_MAX-1];
        int          len;
        t_digit_result r;
        v   = value & VALUE_MASK;
        len = decimal_len(v);
        if (cap == 8'd0) begin
            digits_due.push_back(t_digit_result'{6'd0, 5'd0, u2d_pkg::ST_CAP_ZERO, 1'b1});
            return;
        end
        if (len + 1 > int'(cap)) begin
            digits_due.push_back(t_digit_result'{6'd0, 5'd0, u2d_pkg::ST_CAP_SMALL, 1'b1});
            return;
        end
        // collect least significant first, emit most significant first
        for (int i = 0; i < len; i++) begin
            dig[i] = 4'(v % 64'd10);
            v      = v / 64'd10;
        end
        for (int i = 0; i < len; i++) begin
            r.ch     = u2d_pkg::ASCII_ZERO + 6'(dig[len-1-i]);
            r.count  = 5'(len);
            r.status = u2d_pkg::ST_OK;
            r.last   = (i == len - 1);
            digits_due.push_back(r);
        end
    endfunction

    // offer one request, hold it until accepted, optionally after an idle gap
    task automatic send_request(input logic [63:0] value, input logic [7:0] cap,
                                input t_stim_row row);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push              <= 1'b1;
        i_value           <= value;
        i_buffer_capacity <= cap;
        do @(posedge i_clk); while (full);
        if (row.typed)
            digits_due.push_back(t_digit_result'{row.ch, row.count, row.status, 1'b1});
        else
            predict_conversion(value, cap);
        @(negedge i_clk);
    endtask

    initial begin
        logic [63:0] value;
        logic [7:0]  cap;
        int          len;
        int          pick;
        t_stim_row   plain;

        i_rst_n           = 1'b0;
        push              = 1'b0;
        i_value           = 64'd0;
        i_buffer_capacity = 8'd0;
        error_cnt         = 0;
        quiet             = 1'b0;
        plain             = '{64'd0, 8'd0, 1'b0, u2d_pkg::ST_OK, 6'd0, 5'd0};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++)
            send_request(DIRECTED[k].value, DIRECTED[k].cap, DIRECTED[k]);

        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k >= RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            value = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0) value = value >> $urandom_range(0, 63);
            len  = decimal_len(value);
            pick = $urandom_range(0, 9);
            case (pick)
                0: cap = 8'd0;
                1: cap = 8'(len);
                2: cap = 8'($urandom_range(1, len));
                3, 4: cap = 8'(len + 1);
                5, 6, 7: cap = 8'(len + 1 + $urandom_range(0, 5));
                8: cap = 8'($urandom_range(21, 255));
                default: cap = 8'($urandom);
            endcase
            send_request(value, cap, plain);
        end
        push <= 1'b0;

        while (digits_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random pop bursts, one long hold-off to back the core up
    initial begin
        bit long_hold_done;
        pop            = 1'b0;
        long_hold_done = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!long_hold_done && popped_cnt >= HOLD_AFTER) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    initial popped_cnt = 0;

    always @(posedge i_clk) begin
        t_digit_result want;
        if (i_rst_n && pop && !empty) begin
            popped_cnt++;
            if (digits_due.size() == 0) begin
                $display("%0t unexpected result: actual ch=%0d cnt=%0d st=%0d last=%0d",
                         $time, o_digit_char, o_digit_count, o_status, o_last);
                error_cnt++;
            end else begin
                want = digits_due.pop_front();
                if (o_digit_char !== want.ch || o_digit_count !== want.count ||
                    o_status !== want.status || o_last !== want.last) begin
                    $display("%0t mismatch: expected ch=%0d cnt=%0d st=%0d last=%0d",
                             $time, want.ch, want.count, want.status, want.last);
                    $display("%0t           actual   ch=%0d cnt=%0d st=%0d last=%0d",
                             $time, o_digit_char, o_digit_count, o_status, o_last);
                    error_cnt++;
                end
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t timeout after %0d cycles", $time, cycle_cnt);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
